FILE: sv/wsr_pkg.sv
// package for the wildcard star regex matcher
// shared types, byte codes and sizing constants; no dependencies
`timescale 1ns / 1ps

package wsr_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	// cells evaluated per cycle when a subject byte walks the row
	localparam int LANES = 8;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] DOT_BYTE  = 8'h2E;

	typedef enum logic [1:0] {
		MODE_CLEAR   = 2'd0,
		MODE_APPEND  = 2'd1,
		MODE_SUBJECT = 2'd2,
		MODE_END     = 2'd3
	} mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic start;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} status_t;

endpackage

FILE: sv/wsr_ctrl.sv
// controller for the wildcard star regex matcher
// decodes accepted beats into datapath commands; uses wsr_pkg
`timescale 1ns / 1ps

module wsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_mode,
	output logic              in_ready,
	input  wsr_pkg::status_t  status,
	output wsr_pkg::cmd_t     cmd
);

	wsr_pkg::state_t state_q, state_d;
	wsr_pkg::mode_t  mode;

	assign mode = wsr_pkg::mode_t'(in_mode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			wsr_pkg::ST_IDLE: begin
				// an end beat waits until the result register can take it
				in_ready = (mode != wsr_pkg::MODE_END) || status.out_free;
				if (in_valid && in_ready) begin
					case (mode)
						wsr_pkg::MODE_CLEAR:   cmd.clear  = 1'b1;
						wsr_pkg::MODE_APPEND:  cmd.append = 1'b1;
						wsr_pkg::MODE_SUBJECT: begin
							cmd.start = 1'b1;
							state_d   = wsr_pkg::ST_SCAN;
						end
						wsr_pkg::MODE_END:     cmd.emit   = 1'b1;
						default:               cmd        = '0;
					endcase
				end
			end
			wsr_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
				if (status.last) begin
					state_d = wsr_pkg::ST_IDLE;
				end
			end
			default: state_d = wsr_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: sv/wsr_dpath.sv
// datapath for the wildcard star regex matcher: pattern store, match rows,
// chunked row of match cells and result register; uses wsr_pkg
`timescale 1ns / 1ps

module wsr_dpath #(
	parameter int MAX_PATTERN = wsr_pkg::MAX_PATTERN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wsr_pkg::cmd_t     cmd,
	output wsr_pkg::status_t  status,
	input  logic [7:0]        symbol,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              matched,
	output logic              pattern_overflow
);

	localparam int LW     = $clog2(MAX_PATTERN + 1);
	localparam int IW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int NCHUNK = (MAX_PATTERN + wsr_pkg::LANES - 1) / wsr_pkg::LANES;
	localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	logic [7:0]         pat_q [MAX_PATTERN];
	logic [LW-1:0]      len_q;
	logic               ovf_q;
	logic [MAX_PATTERN:0] esr_q;
	logic [MAX_PATTERN:0] row_q;
	logic [MAX_PATTERN:0] nxt_q;
	logic [7:0]         sym_q;
	logic [CW-1:0]      cnt_q;
	logic               out_valid_q;
	logic               matched_q;
	logic               ovf_out_q;

	logic               room;
	logic               esr_bit;
	logic [MAX_PATTERN:0] esr_upd;
	logic [MAX_PATTERN:0] nc;
	logic [MAX_PATTERN:0] mg;

	assign room = (len_q < LW'(MAX_PATTERN));

	// empty-subject cell of the new prefix: only a star can match nothing
	always_comb begin
		esr_bit = (len_q != '0) && (symbol == wsr_pkg::STAR_BYTE) &&
		          esr_q[LW'(len_q - 1'b1)];
		esr_upd = esr_q;
		if (room) begin
			esr_upd[LW'(len_q + 1'b1)] = esr_bit;
		end
	end

	// one cell per pattern position; the ripple is cut at chunk edges,
	// where the neighbor value comes from nxt_q of the previous cycle
	always_comb begin
		logic hit;
		logic hit_prev;
		logic prev1;
		logic prev2;
		nc = '0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			hit      = (pat_q[j] == wsr_pkg::DOT_BYTE) || (pat_q[j] == sym_q);
			hit_prev = 1'b0;
			prev1    = 1'b0;
			prev2    = 1'b0;
			if (j > 0) begin
				hit_prev = (pat_q[j-1] == wsr_pkg::DOT_BYTE) || (pat_q[j-1] == sym_q);
				prev1    = (((j - 1) / wsr_pkg::LANES) == (j / wsr_pkg::LANES)) ?
				           nc[j] : nxt_q[j];
			end
			if (j > 1) begin
				prev2 = (((j - 2) / wsr_pkg::LANES) == (j / wsr_pkg::LANES)) ?
				        nc[j-1] : nxt_q[j-1];
			end
			if (pat_q[j] != wsr_pkg::STAR_BYTE) begin
				nc[j+1] = row_q[j] && hit;
			end else begin
				nc[j+1] = prev2 || prev1 || ((j > 0) && row_q[j+1] && hit_prev);
			end
			nc[j+1] = nc[j+1] && (LW'(j) < len_q);
		end
	end

	always_comb begin
		mg = '0;
		for (int j = 1; j <= MAX_PATTERN; j++) begin
			mg[j] = (CW'((j - 1) / wsr_pkg::LANES) == cnt_q) ? nc[j] : nxt_q[j];
		end
	end

	assign status.last     = (cnt_q == CW'(NCHUNK - 1));
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.append && room) begin
			pat_q[len_q[IW-1:0]] <= symbol;
		end
		if (cmd.start) begin
			sym_q <= symbol;
		end
		if (cmd.step) begin
			nxt_q <= mg;
		end
		if (cmd.emit) begin
			matched_q <= row_q[len_q];
			ovf_out_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			esr_q       <= (MAX_PATTERN + 1)'(1);
			row_q       <= (MAX_PATTERN + 1)'(1);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
				esr_q <= (MAX_PATTERN + 1)'(1);
				row_q <= (MAX_PATTERN + 1)'(1);
			end
			if (cmd.append) begin
				esr_q <= esr_upd;
				row_q <= esr_upd;
				if (room) begin
					len_q <= LW'(len_q + 1'b1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				cnt_q <= '0;
			end
			if (cmd.step) begin
				cnt_q <= CW'(cnt_q + 1'b1);
				if (status.last) begin
					row_q <= mg;
				end
			end
			if (cmd.emit) begin
				row_q       <= esr_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = ovf_out_q;

endmodule

FILE: sv/wildcard_star_regex_match.sv
// Whole-string matcher for patterns of literal bytes, '.' and '*'.
// Input stream: s_tuser carries the beat kind (clear pattern, append pattern
// byte, subject byte, end of subject), s_tdata carries the byte.
// Output stream: one beat per end-of-subject beat, m_tdata[0] = matched,
// m_tdata[1] = pattern overflow since the last clear.
// Timing: the result of an end beat is in the output register on the next
// cycle. While a subject byte is processed, the row of match cells is
// evaluated eight positions per cycle, and s_tready stays low meanwhile.
// Reset clears the pattern, the overflow flag and both match rows; the
// pattern bytes themselves are not cleared.
// A stalled result holds in the output register; other beats are still taken,
// but the next end beat waits until the pending result is taken.
// Depends on wsr_pkg, wsr_ctrl, wsr_dpath.
`timescale 1ns / 1ps

module wildcard_star_regex_match #(
	parameter int MAX_PATTERN = wsr_pkg::MAX_PATTERN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic [1:0] s_tuser,   // [1:0] mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

	wsr_pkg::cmd_t    cmd;
	wsr_pkg::status_t status;
	logic             matched;
	logic             pattern_overflow;

	wsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	wsr_dpath #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.symbol           (s_tdata),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	assign m_tdata = {6'b0, pattern_overflow, matched};

endmodule

FILE: sv/wsr_checker.sv
// port-level checks for the wildcard star regex matcher
// bound to wildcard_star_regex_match; uses wsr_pkg
`timescale 1ns / 1ps

module wsr_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	logic end_beat;
	logic subj_beat;

	assign end_beat  = s_tvalid && s_tready && (s_tuser == wsr_pkg::MODE_END);
	assign subj_beat = s_tvalid && s_tready && (s_tuser == wsr_pkg::MODE_SUBJECT);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		end_beat |=> m_tvalid)
		else $error("end beat without result");

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(end_beat))
		else $error("result without end beat");

	// the input is not ready directly after a subject byte is taken, while the cell row is busy
	a_subject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		subj_beat |=> !s_tready)
		else $error("beat taken during row update");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:2] == 6'b0))
		else $error("result padding not zero");

endmodule

bind wildcard_star_regex_match wsr_port_checker u_wsr_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
